FILE: rtl/crob_pkg.sv
// ----------------------------------------------------------------------------
// crob_pkg
// Shared types and constants of the clipped raster-op blitter.
// ----------------------------------------------------------------------------
package crob_pkg;

  localparam int unsigned FbWords = 131072;
  localparam int unsigned FbAw    = 17;
  localparam int unsigned PixW    = 16;
  localparam int unsigned DimW    = 11;
  localparam logic [15:0] KeyMask = 16'hE79C;

  typedef enum logic [2:0] {
    CfgDestWidth   = 3'd0,
    CfgDestHeight  = 3'd1,
    CfgPlaceX      = 3'd2,
    CfgPlaceY      = 3'd3,
    CfgImageWidth  = 3'd4,
    CfgImageHeight = 3'd5,
    CfgRasterMode  = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    RopCopy     = 4'd0,
    RopKey      = 4'd1,
    RopHatchBlk = 4'd2,
    RopHatchXor = 4'd3,
    RopAdd      = 4'd4,
    RopSub      = 4'd5,
    RopMul      = 4'd6,
    RopDiv      = 4'd7,
    RopAnd      = 4'd8,
    RopOr       = 4'd9,
    RopXor      = 4'd10
  } rop_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StMul,
    StRead,
    StDiv,
    StOut
  } state_e;

endpackage

FILE: rtl/clipped_raster_op_blitter_core.sv
// ----------------------------------------------------------------------------
// clipped_raster_op_blitter_core
// Blits an RGB565 pixel stream into an internal frame buffer with clipping
// and raster operations; serves frame-buffer reads.
// ----------------------------------------------------------------------------
// Usage: after reset the block clears the 131072-word frame buffer, one word
// per cycle, and accepts no word until done. Then it takes one word at a
// time. A read request, a clipped pixel and a kept pixel all pass address
// multiply, memory read and merge in that order; a kept pixel with a nonzero
// source in divide mode also passes, before the merge, a radix-2 divider that
// retires one quotient bit per cycle. Results wait in an output register
// until taken; the next word is accepted while a result waits, and its own
// result holds in the merge stage until the register frees.
// s_axis_tuser: req_type. s_axis_tdata: src_pixel[15:0], first_pixel[16],
// read_address[33:17], zero padded. m_axis_tdata: wrote[0],
// write_address[17:1], write_value[33:18], read_data[49:34], zero padded.
module clipped_raster_op_blitter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // src_pixel, first_pixel, read_address
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // wrote, write_address, write_value, read_data
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i
);
  import crob_pkg::*;

  logic [15:0] mem [FbWords];
  logic [15:0] rd_q;

  state_e state_q, state_d;
  logic [FbAw-1:0] clr_q;

  logic [10:0] dw_q, dh_q, iw_q, ih_q;
  logic signed [10:0] px_q, py_q;
  logic [3:0] mode_q;

  logic [10:0] col_q, row_q;
  logic hatch_q;

  // latched request
  logic req_q, keep_q;
  logic [15:0] src_q;
  logic [16:0] raddr_q;
  logic raddr_ok_q;
  logic [10:0] drow_q, dcol_q;
  logic [21:0] addr_q;
  logic [15:0] divrem_q, quo_q;
  logic [4:0] dcnt_q;

  logic [55:0] out_q;
  logic ovalid_q;

  logic acc, m_fire, out_go;
  assign s_axis_tready = (state_q == StIdle);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = out_q;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  // hold the merge until the output register is free
  assign out_go = (state_q == StOut) && (!ovalid_q || m_axis_tready);

  logic in_req, in_first;
  logic [15:0] in_src;
  logic [16:0] in_raddr;
  assign in_req = s_axis_tuser;
  assign in_src = s_axis_tdata[15:0];
  assign in_first = s_axis_tdata[16];
  assign in_raddr = s_axis_tdata[33:17];

  // counters after first_pixel restart
  logic [10:0] c_col, c_row;
  logic c_hatch, active, row_in, col_in, wrap;
  logic signed [12:0] drow, dcol;
  always_comb begin
    c_col = in_first ? '0 : col_q;
    c_row = in_first ? '0 : row_q;
    c_hatch = in_first ? 1'b0 : hatch_q;
    active = c_row < ih_q;
    drow = 13'(py_q) + 13'(signed'({2'b0, c_row}));
    dcol = 13'(px_q) + 13'(signed'({2'b0, c_col}));
    row_in = !drow[12] && (drow < 13'(signed'({2'b0, dh_q})));
    col_in = !dcol[12] && (dcol < 13'(signed'({2'b0, dw_q})));
    wrap = (12'(c_col) + 12'd1) >= 12'(iw_q);
  end

  // merge
  logic keyed, w;
  logic [15:0] nv;
  logic addr_ok;
  assign addr_ok = addr_q < 22'(FbWords);
  assign keyed = (src_q & KeyMask) != '0;
  always_comb begin
    w = 1'b0;
    nv = src_q;
    unique case (mode_q)
      RopCopy:     w = 1'b1;
      RopKey:      w = keyed;
      RopHatchBlk, RopHatchXor: begin
        w = keyed || hatch_q;
        nv = keyed ? src_q : '0;
      end
      RopAdd: begin w = 1'b1; nv = rd_q + src_q; end
      RopSub: begin w = 1'b1; nv = rd_q - src_q; end
      RopMul: begin w = 1'b1; nv = 16'(rd_q * src_q); end
      RopDiv: begin w = src_q != '0; nv = quo_q; end
      RopAnd: begin w = src_q != '0; nv = rd_q & src_q; end
      RopOr:  begin w = src_q != '0; nv = rd_q | src_q; end
      RopXor: begin w = src_q != '0; nv = rd_q ^ src_q; end
      default: w = 1'b0;
    endcase
  end
  logic do_wr;
  assign do_wr = keep_q && w && addr_ok;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == FbAw'(FbWords - 1)) state_d = StIdle;
      StIdle:  if (acc) state_d = StMul;
      StMul:   state_d = StRead;
      StRead:  state_d = (keep_q && mode_q == RopDiv && src_q != '0) ? StDiv : StOut;
      StDiv:   if (dcnt_q == 5'd15) state_d = StOut;
      StOut:   if (out_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // pixel address, read in the same cycle it is formed
  logic [21:0] addr_mul;
  assign addr_mul = 22'(drow_q * dw_q) + 22'(dcol_q);

  // memory port: one write, one registered read
  logic [FbAw-1:0] rd_addr;
  assign rd_addr = req_q ? raddr_q : addr_mul[FbAw-1:0];
  always_ff @(posedge clk_i) begin
    if (state_q == StClear) mem[clr_q] <= '0;
    else if (out_go && do_wr) mem[addr_q[FbAw-1:0]] <= nv;
    if (state_q == StMul) rd_q <= mem[rd_addr];
  end

  // divider: restoring, one bit per cycle
  logic [16:0] trial;
  assign trial = {divrem_q, quo_q[15]} - {1'b0, src_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      dw_q <= 11'd320; dh_q <= 11'd240; iw_q <= 11'd320; ih_q <= 11'd240;
      px_q <= '0; py_q <= '0; mode_q <= RopCopy;
      col_q <= '0; row_q <= '0; hatch_q <= 1'b0;
      ovalid_q <= 1'b0;
      out_q <= '0;
      req_q <= 1'b0; keep_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgDestWidth:   dw_q <= cfg_data_i;
          CfgDestHeight:  dh_q <= cfg_data_i;
          CfgPlaceX:      px_q <= cfg_data_i;
          CfgPlaceY:      py_q <= cfg_data_i;
          CfgImageWidth:  iw_q <= cfg_data_i;
          CfgImageHeight: ih_q <= cfg_data_i;
          CfgRasterMode:  mode_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (acc) begin
        req_q <= in_req;
        if (in_req) begin
          keep_q <= 1'b0;
        end else if (!active) begin
          // past the image: hold counters
          keep_q <= 1'b0;
          col_q <= c_col; row_q <= c_row; hatch_q <= c_hatch;
        end else begin
          // advance counters and hatch toggle
          keep_q <= row_in && col_in;
          hatch_q <= c_hatch ^ (row_in && c_col == '0) ^ (row_in && col_in);
          if (wrap) begin
            col_q <= '0; row_q <= c_row + 1'b1;
          end else begin
            col_q <= c_col + 1'b1; row_q <= c_row;
          end
        end
      end
      // drop the result word
      if (out_go) begin
        ovalid_q <= 1'b1;
        out_q <= {6'b0, (req_q && raddr_ok_q) ? rd_q : 16'h0,
                  do_wr ? nv : 16'h0, do_wr ? addr_q[16:0] : 17'h0, do_wr};
      end else if (m_fire) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      src_q <= in_src;
      raddr_q <= in_raddr;
      raddr_ok_q <= 18'(in_raddr) < 18'(FbWords);
      drow_q <= drow[10:0];
      dcol_q <= dcol[10:0];
    end
    if (state_q == StMul) addr_q <= addr_mul;
    if (state_q == StRead) begin
      divrem_q <= '0;
      quo_q <= rd_q;
      dcnt_q <= '0;
    end else if (state_q == StDiv) begin
      dcnt_q <= dcnt_q + 1'b1;
      if (!trial[16]) begin
        divrem_q <= trial[15:0];
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        divrem_q <= {divrem_q[14:0], quo_q[15]};
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> !s_axis_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !m_axis_tready |=> ovalid_q && $stable(m_axis_tdata))
    else $error("result overwritten");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> dcnt_q <= 5'd15) else $error("divider overrun");
`endif
endmodule
